[rtl/sddmm_pkg.sv]
// shared types and constants for the sampled dense-dense matmul block
// request codes, configuration register indexes, controller/datapath structs
// no dependencies
package sddmm_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int VAL_W      = 16;
  localparam int IDX_W      = 6;
  localparam int IP_W       = 24;
  localparam int RES_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_FILT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] INNER_LEN_RST = 7'd64;

  localparam logic signed [IP_W-1:0]  IP_MAX  = 24'sh7fffff;
  localparam logic signed [IP_W-1:0]  IP_MIN  = 24'sh800000;
  localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7fffffff;
  localparam logic signed [RES_W-1:0] RES_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    REQ_LOAD_X = 2'd0,
    REQ_LOAD_Y = 2'd1,
    REQ_ENTRY  = 2'd2
  } req_type_t;

  typedef struct packed {
    logic accept;
    logic start;
    logic step;
    logic sat_en;
    logic mul_en;
    logic fin_en;
    logic out_load;
  } sddmm_cmd_t;

  typedef struct packed {
    logic skip;
    logic last;
    logic busy;
    logic drop;
  } sddmm_sts_t;

endpackage

[rtl/sddmm_ctrl.sv]
// controller: sequences one sparse entry through the datapath
// owns the request handshake and the result valid flag
// depends on sddmm_pkg
module sddmm_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [1:0]              in_req_type,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  output sddmm_pkg::sddmm_cmd_t   cmd,
  input  sddmm_pkg::sddmm_sts_t   sts
);
  import sddmm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RUN   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_MUL   = 6'b001000,
    ST_FIN   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.accept = accept;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_req_type == REQ_ENTRY)) begin
          cmd.start = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts.skip) begin
          state_nxt = ST_DRAIN;
        end else begin
          cmd.step = 1'b1;
          if (sts.last) state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          cmd.sat_en = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin_en = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.drop) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/sddmm_dp.sv]
// datapath: x and y stores, shared multiply-accumulate, scaling and saturation
// also holds the configuration registers and the result register
// depends on sddmm_pkg
module sddmm_dp #(
  parameter int ROWS_MAX  = 64,
  parameter int COLS_MAX  = 64,
  parameter int INNER_MAX = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [sddmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sddmm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [1:0]                              in_req_type,
  input  logic [sddmm_pkg::IDX_W-1:0]             in_row_index,
  input  logic [sddmm_pkg::IDX_W-1:0]             in_col_index,
  input  logic signed [sddmm_pkg::VAL_W-1:0]      in_value,
  output logic [sddmm_pkg::IDX_W-1:0]             out_row,
  output logic [sddmm_pkg::IDX_W-1:0]             out_col,
  output logic signed [sddmm_pkg::RES_W-1:0]      out_value,
  input  sddmm_pkg::sddmm_cmd_t                   cmd,
  output sddmm_pkg::sddmm_sts_t                   sts
);
  import sddmm_pkg::*;

  localparam int XDEPTH = ROWS_MAX * INNER_MAX;
  localparam int YDEPTH = COLS_MAX * INNER_MAX;
  localparam int XAW    = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
  localparam int YAW    = (YDEPTH > 1) ? $clog2(YDEPTH) : 1;
  localparam int KW     = $clog2(INNER_MAX + 1);
  localparam int IW     = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
  localparam int LW     = (KW > CFG_DATA_W) ? KW : CFG_DATA_W;
  localparam int PRD_W  = 2 * VAL_W;
  localparam int ACC_W  = PRD_W + 1 + KW;
  localparam int MUL_W  = IP_W + VAL_W;

  logic [VAL_W-1:0] x_mem [XDEPTH];
  logic [VAL_W-1:0] y_mem [YDEPTH];

  logic [CFG_DATA_W-1:0]     inner_len_r;
  logic                      zero_filt_r;

  logic [IDX_W-1:0]          row_r, col_r;
  logic signed [VAL_W-1:0]   val_r;
  logic [KW-1:0]             k_r, k_nxt;
  logic [IW-1:0]             idx_r;
  logic                      rng_r;
  logic [XAW-1:0]            x_base_r;
  logic [YAW-1:0]            y_base_r;
  logic signed [VAL_W-1:0]   x_rd_r, y_rd_r;
  logic                      rd_vld_r, prod_vld_r;
  logic signed [PRD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [IP_W-1:0]    ip_r;
  logic signed [MUL_W-1:0]   mul_r;
  logic signed [RES_W-1:0]   res_r;
  logic [IDX_W-1:0]          out_row_r, out_col_r;
  logic signed [RES_W-1:0]   out_value_r;

  logic [LW-1:0]             len_ext;
  logic                      x_wr, y_wr;
  logic [XAW-1:0]            x_wr_addr;
  logic [YAW-1:0]            y_wr_addr;
  logic signed [ACC_W-1:0]   acc_sh;
  logic [ACC_W-IP_W:0]       acc_hi;
  logic signed [IP_W-1:0]    ip_nxt;
  logic signed [MUL_W-1:0]   mul_sh;
  logic [MUL_W-RES_W:0]      mul_hi;
  logic signed [RES_W-1:0]   res_nxt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_len_r <= INNER_LEN_RST;
      zero_filt_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_INNER_LEN: inner_len_r <= cfg_data;
        CFG_ZERO_FILT: zero_filt_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // store writes
  assign x_wr = cmd.accept && (in_req_type == REQ_LOAD_X) &&
                (int'(in_row_index) < ROWS_MAX) && (int'(in_col_index) < INNER_MAX);
  assign y_wr = cmd.accept && (in_req_type == REQ_LOAD_Y) &&
                (int'(in_row_index) < INNER_MAX) && (int'(in_col_index) < COLS_MAX);
  assign x_wr_addr = XAW'(int'(in_row_index) * INNER_MAX + int'(in_col_index));
  assign y_wr_addr = YAW'(int'(in_col_index) * INNER_MAX + int'(in_row_index));

  always_ff @(posedge clk) begin
    if (x_wr) x_mem[x_wr_addr] <= in_value;
    if (cmd.step) x_rd_r <= x_mem[x_base_r + XAW'(idx_r)];
  end

  always_ff @(posedge clk) begin
    if (y_wr) y_mem[y_wr_addr] <= in_value;
    if (cmd.step) y_rd_r <= y_mem[y_base_r + YAW'(idx_r)];
  end

  // entry capture and term counter
  assign len_ext = LW'(inner_len_r);
  assign k_nxt   = (len_ext > LW'(INNER_MAX)) ? KW'(INNER_MAX) : KW'(len_ext);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_r    <= in_row_index;
      col_r    <= in_col_index;
      val_r    <= in_value;
      k_r      <= k_nxt;
      rng_r    <= (int'(in_row_index) < ROWS_MAX) && (int'(in_col_index) < COLS_MAX);
      x_base_r <= XAW'(int'(in_row_index) * INNER_MAX);
      y_base_r <= YAW'(int'(in_col_index) * INNER_MAX);
      idx_r    <= '0;
    end else if (cmd.step) begin
      idx_r    <= idx_r + IW'(1);
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.step;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) prod_r <= x_rd_r * y_rd_r;
    if (cmd.start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // inner product to q.8, saturate to 24 bits
  assign acc_sh = acc_r >>> 8;
  assign acc_hi = acc_sh[ACC_W-1:IP_W-1];
  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      ip_nxt = acc_sh[IP_W-1:0];
    end else begin
      ip_nxt = acc_sh[ACC_W-1] ? IP_MIN : IP_MAX;
    end
  end

  // scale by entry value, back to q.8, saturate to 32 bits
  assign mul_sh = mul_r >>> 8;
  assign mul_hi = mul_sh[MUL_W-1:RES_W-1];
  always_comb begin
    if ((&mul_hi) || !(|mul_hi)) begin
      res_nxt = mul_sh[RES_W-1:0];
    end else begin
      res_nxt = mul_sh[MUL_W-1] ? RES_MIN : RES_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sat_en) ip_r  <= ip_nxt;
    if (cmd.mul_en) mul_r <= ip_r * val_r;
    if (cmd.fin_en) res_r <= res_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r   <= row_r;
      out_col_r   <= col_r;
      out_value_r <= res_r;
    end
  end

  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;

  assign sts.skip = !rng_r || (k_r == '0);
  assign sts.last = ((KW'(idx_r) + KW'(1)) == k_r);
  assign sts.busy = rd_vld_r || prod_vld_r;
  assign sts.drop = zero_filt_r && (res_r == '0);

endmodule

[rtl/sampled_dense_dense_matmul_top.sv]
// top level of the sampled dense-dense matmul block
// joins the controller and the datapath; depends on sddmm_pkg, sddmm_ctrl, sddmm_dp
//
// usage
//   input channel: one request per handshake (in_valid high, in_stall low).
//   req_type 0 loads an x element, 1 loads a y element, 2 is a sparse entry.
//   a load never stalls the input and the next request may follow directly.
//   a sparse entry holds in_stall high until its result is loaded into the
//   output register or dropped; with k = min(inner_length, INNER_MAX), the
//   single shared multiply-accumulate unit steps through k terms and drains, then
//   scaling and saturation run; out-of-range row, col or k of zero skip the steps.
//   result channel: one (row, col, value) per entry, held in an output
//   register; loads are taken while a result waits for the receiver.
//   if out_stall stays high, the next entry waits at its end for the slot.
//   with zero_filter set, a zero result is dropped without a handshake.
//   configuration: cfg_wr_en with cfg_index 0 (inner_length) or 1 (zero_filter),
//   to be written only while the block is idle; the block does not enforce it.
//   reset: synchronous, active low; clears the handshake and the configuration
//   registers (inner_length 64, zero_filter 0); store contents are not reset.
module sampled_dense_dense_matmul_top #(
  parameter int ROWS_MAX  = 64,
  parameter int COLS_MAX  = 64,
  parameter int INNER_MAX = 64
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [sddmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sddmm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_req_type,
  input  logic [sddmm_pkg::IDX_W-1:0]             in_row_index,
  input  logic [sddmm_pkg::IDX_W-1:0]             in_col_index,
  input  logic signed [sddmm_pkg::VAL_W-1:0]      in_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [sddmm_pkg::IDX_W-1:0]             out_row,
  output logic [sddmm_pkg::IDX_W-1:0]             out_col,
  output logic signed [sddmm_pkg::RES_W-1:0]      out_value
);
  import sddmm_pkg::*;

  sddmm_cmd_t cmd;
  sddmm_sts_t sts;

  sddmm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  sddmm_dp #(
    .ROWS_MAX  (ROWS_MAX),
    .COLS_MAX  (COLS_MAX),
    .INNER_MAX (INNER_MAX)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_req_type  (in_req_type),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_value     (in_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value),
    .cmd          (cmd),
    .sts          (sts)
  );

  // an accepted entry occupies the block on the next cycle
  a_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req_type == REQ_ENTRY)) |=> in_stall)
    else $error("entry accepted but block not busy");

  // a load or an unknown request never occupies the block
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_req_type != REQ_ENTRY)) |=> !in_stall)
    else $error("load request stalled the block");

  // a new result only appears at the end of an entry's computation
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a computation");

  // the multiply pipeline is empty whenever requests are taken
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !sts.busy)
    else $error("pipeline active while idle");

endmodule

[tb/sampled_dense_dense_matmul_top_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for sampled_dense_dense_matmul_top: loads x and y elements,
// sends sparse entries and checks each (row, col, value) against an in-bench predictor
// depends on sddmm_pkg and the rtl of the block
module sampled_dense_dense_matmul_top_tb;
  import sddmm_pkg::*;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int DRAIN_CYCLES = 80;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PLAN_LEN     = 23;

  typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_VALUE, CHK_NONE} check_t;

  typedef struct packed {
    step_kind_t        kind;
    logic [1:0]        code;
    logic [5:0]        row;
    logic [5:0]        col;
    logic signed [15:0] value;
    check_t            chk;
    logic signed [31:0] want;
  } step_t;

  typedef struct packed {
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
  } product_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = '0;
  logic [IDX_W-1:0] in_row_index = '0;
  logic [IDX_W-1:0] in_col_index = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic signed [RES_W-1:0] out_value;

  sampled_dense_dense_matmul_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_value    (out_value)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [15:0] x_mat [64][64];
  logic signed [15:0] y_mat [64][64];
  bit x_set [64][64];
  bit y_set [64][64];
  logic [6:0] inner_len = INNER_LEN_RST;
  bit zero_filt = 1'b0;

  product_t product_q [$];
  step_t directed_plan [PLAN_LEN];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int requests_sent = 0;
  int entries_sent = 0;
  int results_dropped = 0;
  int results_checked = 0;
  int reg_writes = 0;

  function automatic int active_terms();
    return (inner_len > 7'd64) ? 64 : int'(inner_len);
  endfunction

  function automatic logic signed [31:0] sampled_product(input logic [5:0] r,
                                                         input logic [5:0] c,
                                                         input logic signed [15:0] v);
    logic signed [47:0] dot;
    logic signed [47:0] scaled;
    int terms;
    int t;
    dot = '0;
    terms = active_terms();
    for (t = 0; t < terms; t++) dot += x_mat[r][t] * y_mat[c][t];
    dot = dot >>> 8;
    if (dot > IP_MAX) dot = IP_MAX;
    else if (dot < IP_MIN) dot = IP_MIN;
    scaled = (dot * v) >>> 8;
    if (scaled > RES_MAX) scaled = RES_MAX;
    else if (scaled < RES_MIN) scaled = RES_MIN;
    return scaled[31:0];
  endfunction

  function automatic logic signed [15:0] rand_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'sh0100;
      4: return 16'shffff;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // big dot products share one row and one column to keep the fill cost down
  function automatic logic [5:0] pick_index();
    if (active_terms() > 16) return 6'd0;
    if ($urandom_range(7) != 0) return 6'($urandom_range(3));
    return 6'($urandom_range(63));
  endfunction

  task automatic send_req(input logic [1:0] code, input logic [5:0] r, input logic [5:0] c,
                          input logic signed [15:0] v, input check_t chk,
                          input logic signed [31:0] want);
    product_t pending;
    logic signed [31:0] got;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_req_type <= code;
    in_row_index <= r;
    in_col_index <= c;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    if (code != REQ_RESERVED) requests_sent++;
    case (code)
      REQ_LOAD_X: begin
        x_mat[r][c] = v;
        x_set[r][c] = 1'b1;
      end
      REQ_LOAD_Y: begin
        y_mat[c][r] = v;
        y_set[c][r] = 1'b1;
      end
      REQ_ENTRY: begin
        entries_sent++;
        got = sampled_product(r, c, v);
        pending.row = r;
        pending.col = c;
        pending.value = (chk == CHK_VALUE) ? want : got;
        if (chk == CHK_VALUE || (chk == CHK_MODEL && !(zero_filt && got == 0)))
          product_q = {product_q, pending};
        else
          results_dropped++;
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reg_writes++;
    if (idx == CFG_INNER_LEN) inner_len = data;
    else if (idx == CFG_ZERO_FILT) zero_filt = data[0];
  endtask

  task automatic random_entry();
    logic [5:0] r;
    logic [5:0] c;
    int terms;
    int t;
    r = pick_index();
    c = pick_index();
    terms = active_terms();
    for (t = 0; t < terms; t++)
      if (!x_set[r][t]) send_req(REQ_LOAD_X, r, 6'(t), rand_value(), CHK_MODEL, '0);
    for (t = 0; t < terms; t++)
      if (!y_set[c][t]) send_req(REQ_LOAD_Y, 6'(t), c, rand_value(), CHK_MODEL, '0);
    send_req(REQ_ENTRY, r, c, rand_value(), CHK_MODEL, '0);
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin : check_results
    product_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (product_q.size() == 0) begin
        $error("unexpected result: row %0d col %0d value %0d", out_row, out_col, out_value);
        mismatches++;
      end else begin
        want = product_q.pop_front();
        results_checked++;
        if (out_row !== want.row) begin
          $error("out_row mismatch: expected %0d, got %0d", want.row, out_row);
          mismatches++;
        end
        if (out_col !== want.col) begin
          $error("out_col mismatch: expected %0d, got %0d", want.col, out_col);
          mismatches++;
        end
        if (out_value !== want.value) begin
          $error("out_value mismatch: expected %0d, got %0d", want.value, out_value);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int i;
    int seg;
    int seg_items;
    int seg_entries;
    int roll;
    logic [6:0] seg_len;
    bit seg_filt;

    // two-term products reach the inner saturation with extreme elements
    directed_plan = '{
      '{STEP_CFG, 2'(CFG_INNER_LEN), 6'd0,  6'd0,  16'sd2,      CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_LOAD_X,        6'd0,  6'd0,  16'sh8000,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_LOAD_X,        6'd0,  6'd1,  16'sh8000,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_LOAD_Y,        6'd0,  6'd0,  16'sh8000,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_LOAD_Y,        6'd1,  6'd0,  16'sh8000,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_ENTRY,         6'd0,  6'd0,  16'sd256,    CHK_VALUE, 32'sd8388607},
      '{STEP_REQ, REQ_ENTRY,         6'd0,  6'd0,  16'sd0,      CHK_VALUE, 32'sd0},
      '{STEP_REQ, REQ_ENTRY,         6'd0,  6'd0,  16'sh8000,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_LOAD_Y,        6'd0,  6'd63, 16'sh7fff,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_LOAD_Y,        6'd1,  6'd63, 16'sh7fff,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_LOAD_X,        6'd63, 6'd0,  16'sh7fff,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_LOAD_X,        6'd63, 6'd1,  16'sh8000,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_ENTRY,         6'd63, 6'd63, 16'sh7fff,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_ENTRY,         6'd0,  6'd63, 16'shffff,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_RESERVED,      6'd63, 6'd63, 16'shffff,   CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_RESERVED,      6'd0,  6'd0,  16'sd0,      CHK_MODEL, 32'sd0},
      '{STEP_CFG, 2'(CFG_ZERO_FILT), 6'd0,  6'd0,  16'sd1,      CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_ENTRY,         6'd0,  6'd0,  16'sd0,      CHK_NONE,  32'sd0},
      '{STEP_REQ, REQ_ENTRY,         6'd63, 6'd0,  16'sd1,      CHK_MODEL, 32'sd0},
      '{STEP_CFG, 2'(CFG_INNER_LEN), 6'd0,  6'd0,  16'sd0,      CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_ENTRY,         6'd5,  6'd7,  16'sh7fff,   CHK_NONE,  32'sd0},
      '{STEP_CFG, 2'(CFG_ZERO_FILT), 6'd0,  6'd0,  16'sd0,      CHK_MODEL, 32'sd0},
      '{STEP_REQ, REQ_ENTRY,         6'd5,  6'd7,  16'sh8000,   CHK_VALUE, 32'sd0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 35;
    recv_stall_pct = 45;
    for (i = 0; i < PLAN_LEN; i++) begin
      if (directed_plan[i].kind == STEP_CFG)
        write_reg(directed_plan[i].code[CFG_IDX_W-1:0], directed_plan[i].value[6:0]);
      else
        send_req(directed_plan[i].code, directed_plan[i].row, directed_plan[i].col,
                 directed_plan[i].value, directed_plan[i].chk, directed_plan[i].want);
    end

    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin seg_len = 7'd1;   seg_filt = 1'b0; end
        1: begin seg_len = 7'd127; seg_filt = 1'b1; end
        2: begin seg_len = 7'd64;  seg_filt = 1'b0; end
        3: begin seg_len = 7'($urandom_range(2, 8));   seg_filt = 1'b1; end
        4: begin seg_len = 7'($urandom_range(17, 63)); seg_filt = 1'b0; end
        default: begin seg_len = 7'd64; seg_filt = 1'b1; end
      endcase
      if (seg < 2) begin
        send_idle_pct = 35;
        recv_stall_pct = 45;
      end else if (seg < 4) begin
        send_idle_pct = 45;
        recv_stall_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_reg(CFG_INNER_LEN, seg_len);
      write_reg(CFG_ZERO_FILT, CFG_DATA_W'(seg_filt));

      seg_items = requests_sent;
      seg_entries = entries_sent;
      while (requests_sent - seg_items < 30 || entries_sent - seg_entries < 20) begin
        roll = $urandom_range(19);
        if (roll == 0)
          send_req(REQ_RESERVED, 6'($urandom_range(63)), 6'($urandom_range(63)),
                   rand_value(), CHK_MODEL, '0);
        else if (roll < 8)
          send_req($urandom_range(1) ? REQ_LOAD_Y : REQ_LOAD_X,
                   $urandom_range(1) ? pick_index() : 6'($urandom_range(63)),
                   $urandom_range(1) ? pick_index() : 6'($urandom_range(63)),
                   rand_value(), CHK_MODEL, '0);
        else
          random_entry();
      end
    end

    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests, %0d of them sparse entries, over %0d register writes",
             requests_sent, entries_sent, reg_writes);
    $display("%0d results checked, %0d dropped by the zero filter, %0d mismatches",
             results_checked, results_dropped, mismatches);
    if (mismatches == 0 && product_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/sddmm_pkg.sv
rtl/sddmm_ctrl.sv
rtl/sddmm_dp.sv
rtl/sampled_dense_dense_matmul_top.sv
tb/sampled_dense_dense_matmul_top_tb.sv
